FILE: src/jha_pkg.sv
// shared types, codes and saturation helper for the jackknife histogram accumulator
package jha_pkg;

  localparam int ACC_W = 48;
  localparam int SUM_W = ACC_W + 1;
  localparam int VAL_W = 32;
  localparam int WGT_W = 24;
  localparam int REG_IDX_W = 5;
  localparam int BIN_IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_FULL   = 2'd1,
    CMD_REGION = 2'd2,
    CMD_COMP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_MIN    = 2'd0,
    CFG_INV_WIDTH   = 2'd1,
    CFG_BINS_IN_USE = 2'd2,
    CFG_REGIONS     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              in_range;
    logic [VAL_W-1:0]  bin;
  } bin_map_t;

  typedef struct packed {
    logic                    sat;
    logic signed [ACC_W-1:0] val;
  } clip_t;

  function automatic clip_t clip48(input logic [SUM_W-1:0] v);
    clip_t r;
    r.sat = v[SUM_W-1] != v[SUM_W-2];
    if (!r.sat) begin
      r.val = v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      r.val = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/jha_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module jha_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/jha_bin_map.sv
// maps a q16.16 sample to a bin through one registered multiply
module jha_bin_map import jha_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic signed [VAL_W-1:0] axis_min,
  input  logic [VAL_W-1:0]        inverse_bin_width,
  output bin_map_t                map_res
);

  logic signed [VAL_W:0]  diff;
  logic [2*VAL_W-1:0]     prod;
  bin_map_t               map_next;

  always_comb begin
    diff = {sample_value[VAL_W-1], sample_value} - {axis_min[VAL_W-1], axis_min};
    prod = diff[VAL_W-1:0] * inverse_bin_width;
    if (inverse_bin_width == '0) begin
      map_next.in_range = 1'b1;
      map_next.bin      = '0;
    end else if (diff[VAL_W]) begin
      map_next.in_range = 1'b0;
      map_next.bin      = '0;
    end else begin
      map_next.in_range = 1'b1;
      map_next.bin      = prod[2*VAL_W-1:VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      map_res <= map_next;
    end
  end

endmodule

FILE: src/jackknife_histogram_accumulator.sv
// top level: weighted histogram with jackknife region sub-histograms
//
//   channel  | handshake            | contents
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_stall  | command, region_a, region_b, sample_value,
//            |                      | weight, bin_index
//   out      | out_valid / out_stall| accepted, bin_out, count_out, saturated
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one transaction at a time, through S_MAP (registered bin multiply) and S_READ;
// a rejected item then goes to S_OUT, reads and single-region adds pass S_ADD_A,
// adds with two distinct regions S_ADD_A and S_ADD_B (single region ram read port)
// after reset a pass over the NUM_REGIONS*NUM_BINS addresses zeroes both rams;
// in_stall stays high meanwhile, cfg writes are always taken
// the next input transaction is taken while a result waits on out_stall
module jackknife_histogram_accumulator import jha_pkg::*; #(
  parameter int NUM_BINS    = 64,
  parameter int NUM_REGIONS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [REG_IDX_W-1:0]        region_a,
  input  logic [REG_IDX_W-1:0]        region_b,
  input  logic signed [VAL_W-1:0]     sample_value,
  input  logic signed [WGT_W-1:0]     weight,
  input  logic [BIN_IDX_W-1:0]        bin_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        accepted,
  output logic [BIN_IDX_W-1:0]        bin_out,
  output logic signed [ACC_W-1:0]     count_out,
  output logic                        saturated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [VAL_W-1:0]            cfg_data
);

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int RDEPTH = NUM_REGIONS * NUM_BINS;
  localparam int RA_W   = $clog2(RDEPTH);
  localparam int CNT_W  = 11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_READ,
    S_ADD_A,
    S_ADD_B,
    S_OUT
  } state_t;

  state_t                  state;
  logic                    clearing;
  logic [RA_W-1:0]         clr_addr;

  logic signed [VAL_W-1:0] axis_min;
  logic [VAL_W-1:0]        inverse_bin_width;
  logic [6:0]              bins_in_use;
  logic [5:0]              regions_in_use;

  cmd_t                    cmd_r;
  logic [REG_IDX_W-1:0]    ra_r;
  logic [REG_IDX_W-1:0]    rb_r;
  logic signed [VAL_W-1:0] sample_r;
  logic signed [WGT_W-1:0] weight_r;
  logic [BIN_IDX_W-1:0]    bidx_r;

  bin_map_t                map_res;
  logic [BIN_W-1:0]        bin_r;
  logic [RA_W-1:0]         addr_a_r;
  logic [RA_W-1:0]         addr_b_r;

  logic                    res_ok;
  logic [BIN_IDX_W-1:0]    res_bin;
  logic signed [ACC_W-1:0] res_val;
  logic                    res_sat;

  logic                    is_add;
  logic [VAL_W-1:0]        sel_bin;
  logic                    bin_ok;
  logic                    ra_ok;
  logic                    rb_ok;
  logic                    chk_ok;
  logic [BIN_W-1:0]        bin_idx;
  logic [RA_W-1:0]         addr_a;
  logic [RA_W-1:0]         addr_b;
  logic [BIN_IDX_W-1:0]    bin_lo;

  logic [ACC_W-1:0]        full_rdata;
  logic [ACC_W-1:0]        reg_rdata;
  logic [SUM_W-1:0]        wext;
  clip_t                   full_new;
  clip_t                   reg_new;
  clip_t                   comp;

  logic                    full_we;
  logic [BIN_W-1:0]        full_waddr;
  logic [ACC_W-1:0]        full_wdata;
  logic                    reg_we;
  logic [RA_W-1:0]         reg_waddr;
  logic [ACC_W-1:0]        reg_wdata;
  logic [RA_W-1:0]         reg_raddr;
  logic                    out_free;

  assign in_stall  = clearing || (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  jha_bin_map u_bin_map (
    .clk               (clk),
    .en                (state == S_MAP),
    .sample_value      (sample_r),
    .axis_min          (axis_min),
    .inverse_bin_width (inverse_bin_width),
    .map_res           (map_res)
  );

  always_comb begin
    is_add  = cmd_r == CMD_ADD;
    sel_bin = is_add ? map_res.bin : VAL_W'(bidx_r);
    bin_ok  = (sel_bin < VAL_W'(bins_in_use)) && (sel_bin < VAL_W'(NUM_BINS));
    ra_ok   = (CNT_W'(ra_r) < CNT_W'(regions_in_use)) && (CNT_W'(ra_r) < CNT_W'(NUM_REGIONS));
    rb_ok   = (CNT_W'(rb_r) < CNT_W'(regions_in_use)) && (CNT_W'(rb_r) < CNT_W'(NUM_REGIONS));
    if (is_add) begin
      chk_ok = map_res.in_range && bin_ok && ra_ok && rb_ok;
    end else begin
      chk_ok = bin_ok && (cmd_r == CMD_FULL || ra_ok);
    end
    bin_idx = sel_bin[BIN_W-1:0];
    addr_a  = RA_W'(ra_r) * RA_W'(NUM_BINS) + RA_W'(bin_idx);
    addr_b  = RA_W'(rb_r) * RA_W'(NUM_BINS) + RA_W'(bin_idx);
    if (!is_add) begin
      bin_lo = bidx_r;
    end else if (chk_ok) begin
      bin_lo = sel_bin[BIN_IDX_W-1:0];
    end else begin
      bin_lo = '0;
    end
  end

  always_comb begin
    wext     = {{(SUM_W-WGT_W){weight_r[WGT_W-1]}}, weight_r};
    full_new = clip48({full_rdata[ACC_W-1], full_rdata} + wext);
    reg_new  = clip48({reg_rdata[ACC_W-1], reg_rdata} + wext);
    comp     = clip48({full_rdata[ACC_W-1], full_rdata} - {reg_rdata[ACC_W-1], reg_rdata});
  end

  always_comb begin
    full_we    = 1'b0;
    full_waddr = bin_r;
    full_wdata = full_new.val;
    reg_we     = 1'b0;
    reg_waddr  = addr_a_r;
    reg_wdata  = reg_new.val;
    reg_raddr  = addr_a;
    if (clearing) begin
      full_we    = {1'b0, clr_addr} < (RA_W+1)'(NUM_BINS);
      full_waddr = clr_addr[BIN_W-1:0];
      full_wdata = '0;
      reg_we     = 1'b1;
      reg_waddr  = clr_addr;
      reg_wdata  = '0;
    end else if (state == S_ADD_A && is_add) begin
      full_we = 1'b1;
      reg_we  = 1'b1;
    end else if (state == S_ADD_B) begin
      reg_we    = 1'b1;
      reg_waddr = addr_b_r;
    end
    if (state == S_ADD_A) begin
      reg_raddr = addr_b_r;
    end
  end

  jha_ram #(
    .WIDTH (ACC_W),
    .DEPTH (NUM_BINS)
  ) u_full_ram (
    .clk   (clk),
    .we    (full_we),
    .waddr (full_waddr),
    .wdata (full_wdata),
    .raddr (bin_idx),
    .rdata (full_rdata)
  );

  jha_ram #(
    .WIDTH (ACC_W),
    .DEPTH (RDEPTH)
  ) u_region_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      clearing          <= 1'b1;
      clr_addr          <= '0;
      out_valid         <= 1'b0;
      axis_min          <= '0;
      inverse_bin_width <= 32'd65536;
      bins_in_use       <= 7'd64;
      regions_in_use    <= 6'd32;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == RA_W'(RDEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_AXIS_MIN:    axis_min          <= cfg_data;
          CFG_INV_WIDTH:   inverse_bin_width <= cfg_data;
          CFG_BINS_IN_USE: bins_in_use       <= cfg_data[6:0];
          CFG_REGIONS:     regions_in_use    <= cfg_data[5:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r    <= cmd_t'(command);
            ra_r     <= region_a;
            rb_r     <= region_b;
            sample_r <= sample_value;
            weight_r <= weight;
            bidx_r   <= bin_index;
            state    <= S_MAP;
          end
        end
        S_MAP: begin
          state <= S_READ;
        end
        S_READ: begin
          bin_r    <= bin_idx;
          addr_a_r <= addr_a;
          addr_b_r <= addr_b;
          res_ok   <= chk_ok;
          res_bin  <= bin_lo;
          res_val  <= '0;
          res_sat  <= 1'b0;
          state    <= chk_ok ? S_ADD_A : S_OUT;
        end
        S_ADD_A: begin
          case (cmd_r)
            CMD_ADD: begin
              res_val <= full_new.val;
              res_sat <= full_new.sat || reg_new.sat;
            end
            CMD_FULL:   res_val <= full_rdata;
            CMD_REGION: res_val <= reg_rdata;
            CMD_COMP: begin
              res_val <= comp.val;
              res_sat <= comp.sat;
            end
            default: ;
          endcase
          state <= (is_add && ra_r != rb_r) ? S_ADD_B : S_OUT;
        end
        S_ADD_B: begin
          res_sat <= res_sat || reg_new.sat;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            accepted  <= res_ok;
            bin_out   <= res_bin;
            count_out <= res_val;
            saturated <= res_sat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_map: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_MAP)
    else $error("accepted transaction did not enter bin mapping");

  a_reject_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !saturated && count_out == '0)
    else $error("rejected result carries a count or saturation");

  a_second_region_distinct: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD_B |-> addr_b_r != addr_a_r)
    else $error("second region update hits the first region's entry");

  a_clear_ends_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> state == S_IDLE && !out_valid)
    else $error("work started during the clearing pass");
`endif

endmodule

FILE: sim/histogram_checker.sv
// checker for the jackknife histogram accumulator: tracks config, predicts each result, compares
module histogram_checker import jha_pkg::*; #(
  parameter int NUM_BINS    = 64,
  parameter int NUM_REGIONS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              command,
  input  logic [REG_IDX_W-1:0]    region_a,
  input  logic [REG_IDX_W-1:0]    region_b,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic signed [WGT_W-1:0] weight,
  input  logic [BIN_IDX_W-1:0]    bin_index,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    accepted,
  input  logic [BIN_IDX_W-1:0]    bin_out,
  input  logic signed [ACC_W-1:0] count_out,
  input  logic                    saturated,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data,
  output int                      failures,
  output int                      pending,
  output int                      results_checked,
  output int                      adds_binned,
  output int                      reads_served
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                    accepted;
    logic [BIN_IDX_W-1:0]    bin;
    logic signed [ACC_W-1:0] count;
    logic                    saturated;
  } bin_result_t;

  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -ACC_HI - 64'sd1;

  longint full_bins [NUM_BINS];
  longint region_hist [NUM_REGIONS * NUM_BINS];
  logic signed [VAL_W-1:0] axis_min_q;
  logic [VAL_W-1:0] inv_width_q;
  logic [6:0] bins_q;
  logic [5:0] regions_q;
  bin_result_t expected_bins [$];

  function automatic longint clamp_acc(input longint s, inout bit sat);
    if (s > ACC_HI) begin
      sat = 1'b1;
      return ACC_HI;
    end
    if (s < ACC_LO) begin
      sat = 1'b1;
      return ACC_LO;
    end
    return s;
  endfunction

  function automatic bin_result_t predict_histogram(input cmd_t op,
                                                    input logic [REG_IDX_W-1:0] ra,
                                                    input logic [REG_IDX_W-1:0] rb,
                                                    input logic signed [VAL_W-1:0] sv,
                                                    input logic signed [WGT_W-1:0] w,
                                                    input logic [BIN_IDX_W-1:0] bi);
    bin_result_t r;
    longint diff;
    longint unsigned prod;
    longint unsigned bin_idx;
    int nb;
    int nr;
    int ia;
    int ib;
    bit ok;
    bit sat;
    r = '0;
    sat = 1'b0;
    nb = (int'(bins_q) < NUM_BINS) ? int'(bins_q) : NUM_BINS;
    nr = (int'(regions_q) < NUM_REGIONS) ? int'(regions_q) : NUM_REGIONS;
    if (op == CMD_ADD) begin
      ok = 1'b1;
      bin_idx = 0;
      if (inv_width_q != 0) begin
        diff = longint'(sv) - longint'(axis_min_q);
        if (diff < 0) begin
          ok = 1'b0;
        end else begin
          prod = longint'(unsigned'(diff)) * longint'({32'd0, inv_width_q});
          bin_idx = prod >> 32;
        end
      end
      if (ok && bin_idx < nb && ra < nr && rb < nr) begin
        ia = int'(ra) * NUM_BINS + int'(bin_idx);
        ib = int'(rb) * NUM_BINS + int'(bin_idx);
        full_bins[bin_idx] = clamp_acc(full_bins[bin_idx] + longint'(w), sat);
        region_hist[ia] = clamp_acc(region_hist[ia] + longint'(w), sat);
        if (ra != rb) begin
          region_hist[ib] = clamp_acc(region_hist[ib] + longint'(w), sat);
        end
        r.accepted = 1'b1;
        r.bin = bin_idx[BIN_IDX_W-1:0];
        r.count = full_bins[bin_idx][ACC_W-1:0];
        r.saturated = sat;
      end
    end else begin
      r.bin = bi;
      if (bi < nb && (op == CMD_FULL || ra < nr)) begin
        ia = int'(ra) * NUM_BINS + int'(bi);
        r.accepted = 1'b1;
        case (op)
          CMD_FULL: begin
            r.count = full_bins[bi][ACC_W-1:0];
          end
          CMD_REGION: begin
            r.count = region_hist[ia][ACC_W-1:0];
          end
          default: begin
            r.count = 48'(clamp_acc(full_bins[bi] - region_hist[ia], sat));
            r.saturated = sat;
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bin_result_t e;
    bin_result_t p;
    if (rst) begin
      foreach (full_bins[i]) full_bins[i] = 0;
      foreach (region_hist[i]) region_hist[i] = 0;
      axis_min_q = '0;
      inv_width_q = 32'd65536;
      bins_q = 7'd64;
      regions_q = 6'd32;
      expected_bins.delete();
      failures = 0;
      results_checked = 0;
      adds_binned = 0;
      reads_served = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_bins.size() == 0) begin
          $error("result with no transaction pending: bin_out %0d, count_out %0d",
                 bin_out, count_out);
          failures++;
        end else begin
          e = expected_bins.pop_front();
          if (accepted !== e.accepted) begin
            $error("accepted mismatch: expected %0d, actual %0d", e.accepted, accepted);
            failures++;
          end
          if (bin_out !== e.bin) begin
            $error("bin_out mismatch: expected %0d, actual %0d", e.bin, bin_out);
            failures++;
          end
          if (count_out !== e.count) begin
            $error("count_out mismatch: expected %0d, actual %0d", e.count, count_out);
            failures++;
          end
          if (saturated !== e.saturated) begin
            $error("saturated mismatch: expected %0d, actual %0d", e.saturated, saturated);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        p = predict_histogram(cmd_t'(command), region_a, region_b, sample_value, weight,
                              bin_index);
        if (cmd_t'(command) == CMD_ADD) begin
          if (p.accepted) adds_binned++;
        end else begin
          if (p.accepted) reads_served++;
        end
        expected_bins.push_back(p);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_AXIS_MIN:    axis_min_q = cfg_data;
          CFG_INV_WIDTH:   inv_width_q = cfg_data;
          CFG_BINS_IN_USE: bins_q = cfg_data[6:0];
          CFG_REGIONS:     regions_q = cfg_data[5:0];
          default: ;
        endcase
      end
    end
    pending = expected_bins.size();
  end

endmodule

FILE: sim/tb_jackknife_histogram_accumulator.sv
// testbench top for the jackknife histogram accumulator: stimulus, flow control, verdict
module tb_jackknife_histogram_accumulator import jha_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BINS = 64;
  localparam int NUM_REGIONS = 32;
  localparam int QUIET_LIMIT = 8000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] command;
  logic [REG_IDX_W-1:0] region_a;
  logic [REG_IDX_W-1:0] region_b;
  logic signed [VAL_W-1:0] sample_value;
  logic signed [WGT_W-1:0] weight;
  logic [BIN_IDX_W-1:0] bin_index;
  logic out_valid;
  logic out_stall;
  logic accepted;
  logic [BIN_IDX_W-1:0] bin_out;
  logic signed [ACC_W-1:0] count_out;
  logic saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0] cfg_data;

  int failures;
  int pending;
  int results_checked;
  int adds_binned;
  int reads_served;

  int send_pct;
  int recv_pct;
  int hold_left;
  int quiet;
  int sent_total;

  logic [VAL_W-1:0] cur_min;
  logic [VAL_W-1:0] cur_inv;
  int cur_bins;
  int cur_regions;

  jackknife_histogram_accumulator #(
    .NUM_BINS(NUM_BINS),
    .NUM_REGIONS(NUM_REGIONS)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .region_a(region_a), .region_b(region_b),
    .sample_value(sample_value), .weight(weight), .bin_index(bin_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .bin_out(bin_out), .count_out(count_out), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  histogram_checker #(
    .NUM_BINS(NUM_BINS),
    .NUM_REGIONS(NUM_REGIONS)
  ) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .region_a(region_a), .region_b(region_b),
    .sample_value(sample_value), .weight(weight), .bin_index(bin_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .bin_out(bin_out), .count_out(count_out), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending), .results_checked(results_checked),
    .adds_binned(adds_binned), .reads_served(reads_served)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input cmd_t op, input logic [REG_IDX_W-1:0] ra,
                           input logic [REG_IDX_W-1:0] rb, input logic [VAL_W-1:0] sv,
                           input logic [WGT_W-1:0] w, input logic [BIN_IDX_W-1:0] bi);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= op;
    region_a <= ra;
    region_b <= rb;
    sample_value <= sv;
    weight <= w;
    bin_index <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [VAL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [VAL_W-1:0] amin, input logic [VAL_W-1:0] inv,
                               input logic [6:0] nb, input logic [5:0] nr);
    wait_idle();
    write_reg(CFG_AXIS_MIN, amin);
    write_reg(CFG_INV_WIDTH, inv);
    write_reg(CFG_BINS_IN_USE, {25'd0, nb});
    write_reg(CFG_REGIONS, {26'd0, nr});
    cfg_valid <= 1'b0;
    cur_min = amin;
    cur_inv = inv;
    cur_bins = int'(nb);
    cur_regions = int'(nr);
  endtask

  task automatic send_random();
    cmd_t op;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic [VAL_W-1:0] sv;
    logic [WGT_W-1:0] w;
    logic [BIN_IDX_W-1:0] bi;
    int lim_b;
    int lim_r;
    longint unsigned span;
    int pick;
    lim_b = (cur_bins < 1) ? 1 : ((cur_bins > NUM_BINS) ? NUM_BINS : cur_bins);
    lim_r = (cur_regions < 1) ? 1 : ((cur_regions > NUM_REGIONS) ? NUM_REGIONS : cur_regions);
    op = ($urandom_range(0, 99) < 55) ? CMD_ADD : cmd_t'($urandom_range(1, 3));
    ra = REG_IDX_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, lim_r - 1));
    rb = REG_IDX_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, lim_r - 1));
    bi = BIN_IDX_W'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, lim_b - 1));
    pick = $urandom_range(0, 99);
    if (pick < 15 || cur_inv == 0) begin
      sv = $urandom;
    end else if (pick < 25) begin
      sv = cur_min - $urandom_range(1, 65536);
    end else begin
      span = ((longint'(lim_b) + 1) << 32) / cur_inv;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      sv = cur_min + $urandom_range(0, int'(span));
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) w = 24'h7F_FFFF;
    else if (pick == 1) w = 24'h80_0000;
    else w = WGT_W'($urandom);
    send_item(op, ra, rb, sv, w, bi);
  endtask

  task automatic run_block(input logic [VAL_W-1:0] amin, input logic [VAL_W-1:0] inv,
                           input logic [6:0] nb, input logic [5:0] nr,
                           input int s_pct, input int r_pct, input int count,
                           input int hold_at, input int pause_at);
    apply_setting(amin, inv, nb, nr);
    send_pct = s_pct;
    recv_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_left = HOLD_OFF_CYCLES;
      if (i == pause_at) wait_idle();
      send_random();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_ADD;
    region_a = '0;
    region_b = '0;
    sample_value = '0;
    weight = '0;
    bin_index = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AXIS_MIN;
    cfg_data = '0;
    send_pct = 22;
    recv_pct = 68;
    hold_left = 0;
    quiet = 0;
    sent_total = 0;
    cur_min = '0;
    cur_inv = 32'd65536;
    cur_bins = 64;
    cur_regions = 32;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset configuration: empty reads, range edges, same and distinct regions
    send_item(CMD_FULL,   5'd0,  5'd0,  32'h0000_0000, 24'h00_0000, 6'd0);
    send_item(CMD_REGION, 5'd31, 5'd0,  32'h0000_0000, 24'h00_0000, 6'd63);
    send_item(CMD_COMP,   5'd31, 5'd31, 32'h0000_0000, 24'h00_0000, 6'd63);
    send_item(CMD_ADD,    5'd0,  5'd0,  32'h0000_0000, 24'h7F_FFFF, 6'd0);
    send_item(CMD_ADD,    5'd31, 5'd5,  32'h003F_FFFF, 24'h80_0000, 6'd0);
    send_item(CMD_ADD,    5'd5,  5'd31, 32'h003F_0000, 24'h00_0001, 6'd63);
    send_item(CMD_ADD,    5'd1,  5'd2,  32'h0040_0000, 24'h12_3456, 6'd0);
    send_item(CMD_ADD,    5'd1,  5'd2,  32'hFFFF_FFFF, 24'h12_3456, 6'd0);
    send_item(CMD_ADD,    5'd1,  5'd2,  32'h7FFF_FFFF, 24'h7F_FFFF, 6'd0);
    send_item(CMD_ADD,    5'd1,  5'd2,  32'h8000_0000, 24'h80_0000, 6'd0);
    send_item(CMD_ADD,    5'd3,  5'd3,  32'h0005_8000, 24'hFF_FFFF, 6'd0);
    send_item(CMD_ADD,    5'd31, 5'd31, 32'h0020_0000, 24'h7F_FFFF, 6'd63);
    send_item(CMD_FULL,   5'd31, 5'd31, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd63);
    send_item(CMD_REGION, 5'd31, 5'd0,  32'h0000_0000, 24'h00_0000, 6'd63);
    send_item(CMD_REGION, 5'd5,  5'd31, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd63);
    send_item(CMD_COMP,   5'd31, 5'd0,  32'h0000_0000, 24'h00_0000, 6'd63);
    send_item(CMD_COMP,   5'd5,  5'd0,  32'h0000_0000, 24'h00_0000, 6'd63);
    send_item(CMD_COMP,   5'd0,  5'd0,  32'h0000_0000, 24'h00_0000, 6'd0);
    send_item(CMD_REGION, 5'd3,  5'd31, 32'h0000_0000, 24'h00_0000, 6'd5);
    send_item(CMD_FULL,   5'd0,  5'd0,  32'h0000_0000, 24'h00_0000, 6'd5);
    send_item(CMD_COMP,   5'd3,  5'd0,  32'h0000_0000, 24'h00_0000, 6'd5);
    send_item(CMD_FULL,   5'd31, 5'd31, 32'hFFFF_FFFF, 24'hFF_FFFF, 6'd32);

    // sender 22 / receiver 68
    run_block(32'hFFFB_0000, 32'h0002_0000, 7'd16,  6'd4,  22, 68, 300, -1, -1);
    run_block(32'h8000_0000, 32'hFFFF_FFFF, 7'd64,  6'd32, 22, 68, 200, -1, -1);
    // sender 68 / receiver 22
    run_block(32'h7FFF_FFFF, 32'h0000_0001, 7'd64,  6'd32, 68, 22, 50,  -1, -1);
    run_block(32'h0000_0000, 32'h0000_0000, 7'd1,   6'd1,  68, 22, 200, -1, -1);
    run_block(32'h0010_0000, 32'h0000_8000, 7'd127, 6'd63, 68, 22, 250, -1, 120);
    // no idling, apart from one long receiver hold-off
    run_block(32'h0000_0000, 32'h0001_0000, 7'd0,   6'd0,  0,  0,  40,  -1, -1);
    run_block(32'h0000_0000, 32'h0001_0000, 7'd40,  6'd20, 0,  0,  400, 100, -1);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run: %0d transactions sent, %0d results checked over 8 register settings",
             sent_total, results_checked);
    $display("     %0d adds landed in a bin, %0d reads in range", adds_binned, reads_served);
    if (failures == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
src/jha_pkg.sv
src/jha_ram.sv
src/jha_bin_map.sv
src/jackknife_histogram_accumulator.sv
sim/histogram_checker.sv
sim/tb_jackknife_histogram_accumulator.sv
